/* rtl/char_lcd_nibble_command_engine_defines.svh */
// Assertion macro for the LCD command engine
`ifndef CHAR_LCD_NIBBLE_COMMAND_ENGINE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_COMMAND_ENGINE_DEFINES_SVH
// Concurrent assertion on the rising clock edge, off during reset
`define CLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`endif

/* rtl/clcd_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, constants and helpers for the character LCD command engine.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int unsigned DefColumns = 16;
  localparam int unsigned DefRows    = 2;

  typedef enum logic [2:0] {
    CMD_INIT = 3'd0, CMD_BYTE = 3'd1, CMD_DATA = 3'd2, CMD_GOTO = 3'd3,
    CMD_CLEAR = 3'd4, CMD_UNUM = 3'd5, CMD_SNUM = 3'd6, CMD_NONE = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] value;
    logic [7:0]  column;
    logic [7:0]  row;
  } in_item_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic        strobe_res;
    logic [16:0] wait_us;
    logic        last;
  } out_item_t;

  // Classified job handed from front to back
  typedef enum logic [2:0] {
    JOB_INIT = 3'd0, JOB_BYTES = 3'd1, JOB_CLEAR = 3'd2, JOB_NUMBER = 3'd3
  } job_e;

  typedef struct packed {
    job_e        job;
    logic        rs;
    logic [7:0]  byte_val;
    logic        sign_en;   // emit sign byte first
    logic        negative;
    logic [15:0] mag;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0, BK_CONV = 2'd1, BK_EMIT = 2'd2
  } bk_state_e;

  localparam logic [16:0] WaitStrobe = 17'd50;
  localparam logic [16:0] WaitCmdLo  = 17'd2050;
  localparam logic [16:0] WaitDataLo = 17'd1050;
  localparam logic [16:0] WaitClrLo  = 17'd4050;

  localparam int unsigned InitLen = 15;

  // Fixed init run, one entry per result item
  function automatic out_item_t init_item(input logic [3:0] idx);
    out_item_t r;
    r = '{reg_select: 1'b0, nibble: 4'h0, strobe_res: 1'b1,
          wait_us: WaitStrobe, last: 1'b0};
    unique case (idx)
      4'd0:  begin r.strobe_res = 1'b0; r.wait_us = 17'd100000; end
      4'd1:  begin r.nibble = 4'h3; r.wait_us = 17'd5050; end
      4'd2:  begin r.nibble = 4'h3; r.wait_us = 17'd1050; end
      4'd3:  begin r.nibble = 4'h3; r.wait_us = 17'd1050; end
      4'd4:  begin r.nibble = 4'h2; r.wait_us = 17'd1050; end
      4'd5:  r.nibble = 4'h2;
      4'd6:  begin r.nibble = 4'h8; r.wait_us = WaitCmdLo; end
      4'd7:  r.nibble = 4'h0;
      4'd8:  begin r.nibble = 4'h8; r.wait_us = WaitCmdLo; end
      4'd9:  r.nibble = 4'h0;
      4'd10: begin r.nibble = 4'h1; r.wait_us = WaitClrLo; end
      4'd11: r.nibble = 4'h0;
      4'd12: begin r.nibble = 4'h6; r.wait_us = WaitCmdLo; end
      4'd13: r.nibble = 4'h0;
      4'd14: begin r.nibble = 4'hC; r.wait_us = WaitCmdLo; r.last = 1'b1; end
      default: r.nibble = 4'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/clcd_front.sv */
// ----------------------------------------------------------------------------
// clcd_front
// Accepts commands, classifies them and drops those that produce nothing.
// ----------------------------------------------------------------------------
module clcd_front #(
  parameter int unsigned Columns = clcd_pkg::DefColumns,
  parameter int unsigned Rows    = clcd_pkg::DefRows
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  clcd_pkg::in_item_t in_data_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output clcd_pkg::job_t     job_o
);

  logic           valid_q, valid_d;
  clcd_pkg::job_t job_q, job_d;
  logic           keep;
  logic           col_ok, row_ok;
  logic [7:0]     base;

  assign in_ready_o  = !valid_q || job_ready_i;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  assign col_ok = {24'd0, in_data_i.column} < 32'(Columns);
  assign row_ok = {24'd0, in_data_i.row} < 32'(Rows);
  assign base   = (in_data_i.row == 8'd0) ? 8'h80 : 8'hC0;

  always_comb begin
    job_d          = job_q;
    keep           = 1'b1;
    job_d.rs       = 1'b0;
    job_d.sign_en  = 1'b0;
    job_d.negative = 1'b0;
    job_d.mag      = in_data_i.value;
    job_d.byte_val = in_data_i.value[7:0];
    unique case (clcd_pkg::cmd_e'(in_data_i.cmd))
      clcd_pkg::CMD_INIT:  job_d.job = clcd_pkg::JOB_INIT;
      clcd_pkg::CMD_BYTE:  job_d.job = clcd_pkg::JOB_BYTES;
      clcd_pkg::CMD_DATA:  begin job_d.job = clcd_pkg::JOB_BYTES; job_d.rs = 1'b1; end
      clcd_pkg::CMD_GOTO:  begin
        job_d.job      = clcd_pkg::JOB_BYTES;
        job_d.byte_val = base + in_data_i.column;
        keep           = col_ok && row_ok;
      end
      clcd_pkg::CMD_CLEAR: job_d.job = clcd_pkg::JOB_CLEAR;
      clcd_pkg::CMD_UNUM:  begin job_d.job = clcd_pkg::JOB_NUMBER; job_d.rs = 1'b1; end
      clcd_pkg::CMD_SNUM:  begin
        job_d.job      = clcd_pkg::JOB_NUMBER;
        job_d.rs       = 1'b1;
        job_d.sign_en  = 1'b1;
        job_d.negative = in_data_i.value[15];
        job_d.mag      = in_data_i.value[15] ? (16'd0 - in_data_i.value) : in_data_i.value;
      end
      clcd_pkg::CMD_NONE:  keep = 1'b0;
      default:             keep = 1'b0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (job_ready_i) valid_d = 1'b0;
    if (in_valid_i && in_ready_o && keep) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && keep) job_q <= job_d;
  end

endmodule

/* rtl/clcd_queue.sv */
// ----------------------------------------------------------------------------
// clcd_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module clcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  clcd_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output clcd_pkg::job_t rd_data_o
);

  clcd_pkg::job_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

/* rtl/clcd_back.sv */
// ----------------------------------------------------------------------------
// clcd_back
// Expands one job into nibble transfers; converts numbers one digit a cycle.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_command_engine_defines.svh"
module clcd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  clcd_pkg::job_t      job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clcd_pkg::out_item_t out_data_o
);

  clcd_pkg::bk_state_e state_q, state_d;
  clcd_pkg::job_t      job_q;
  logic [15:0]         rem_q, rem_d;
  logic [3:0]          dig_q [5];
  logic [2:0]          ndig_q, ndig_d;   // digits found
  logic [3:0]          idx_q, idx_d;     // item index within run
  logic [3:0]          nitems;
  logic                ov_q, ov_d;
  clcd_pkg::out_item_t od_q, od_d;
  logic                slot_free, take_job, emit;
  logic [3:0]          qdig;
  logic [15:0]         quot;
  logic [31:0]         prod;
  logic [7:0]          cur_byte;
  logic [2:0]          byte_no, dsel;
  clcd_pkg::out_item_t item;

  // Divide by ten through reciprocal multiply
  assign prod = {16'd0, rem_q} * 32'd52429;
  assign quot = {3'd0, prod[31:19]};
  assign qdig = 4'(rem_q - quot * 16'd10);

  assign slot_free   = !ov_q || out_ready_i;
  assign job_ready_o = state_q == clcd_pkg::BK_IDLE;
  assign take_job    = job_valid_i && job_ready_o;
  assign emit        = state_q == clcd_pkg::BK_EMIT && slot_free;

  always_comb begin
    unique case (job_q.job)
      clcd_pkg::JOB_INIT:   nitems = 4'(clcd_pkg::InitLen);
      clcd_pkg::JOB_BYTES:  nitems = 4'd2;
      clcd_pkg::JOB_CLEAR:  nitems = 4'd4;
      clcd_pkg::JOB_NUMBER: nitems = 4'({ndig_q, 1'b0}) + (job_q.sign_en ? 4'd2 : 4'd0);
      default:              nitems = 4'd2;
    endcase
  end

  always_comb begin
    byte_no = idx_q[3:1];
    dsel    = 3'd0;
    cur_byte = job_q.byte_val;
    if (job_q.job == clcd_pkg::JOB_CLEAR) begin
      cur_byte = (byte_no == 3'd0) ? 8'h01 : 8'h80;
    end else if (job_q.job == clcd_pkg::JOB_NUMBER) begin
      if (job_q.sign_en && byte_no == 3'd0) begin
        cur_byte = job_q.negative ? 8'h2D : 8'h20;
      end else begin
        dsel     = ndig_q - 3'd1 - (byte_no - (job_q.sign_en ? 3'd1 : 3'd0));
        cur_byte = {4'h3, dig_q[dsel]};
      end
    end
    item.reg_select = job_q.rs;
    item.strobe_res = 1'b1;
    item.nibble     = idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
    item.wait_us    = !idx_q[0] ? clcd_pkg::WaitStrobe
                    : job_q.rs ? clcd_pkg::WaitDataLo
                    : (job_q.job == clcd_pkg::JOB_CLEAR && byte_no == 3'd0)
                      ? clcd_pkg::WaitClrLo : clcd_pkg::WaitCmdLo;
    item.last       = idx_q == nitems - 4'd1;
    if (job_q.job == clcd_pkg::JOB_INIT) item = clcd_pkg::init_item(idx_q);
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    ndig_d  = ndig_q;
    idx_d   = idx_q;
    ov_d    = ov_q && !out_ready_i;
    od_d    = od_q;
    unique case (state_q)
      clcd_pkg::BK_IDLE: if (take_job) begin
        idx_d  = 4'd0;
        ndig_d = 3'd0;
        rem_d  = job_i.mag;
        state_d = (job_i.job == clcd_pkg::JOB_NUMBER) ? clcd_pkg::BK_CONV
                                                       : clcd_pkg::BK_EMIT;
      end
      clcd_pkg::BK_CONV: begin
        // one digit a cycle, least significant first; zero still yields a digit
        rem_d  = quot;
        ndig_d = ndig_q + 3'd1;
        if (quot == 16'd0) state_d = clcd_pkg::BK_EMIT;
      end
      clcd_pkg::BK_EMIT: if (slot_free) begin
        ov_d  = 1'b1;
        od_d  = item;
        idx_d = idx_q + 4'd1;
        if (item.last) state_d = clcd_pkg::BK_IDLE;
      end
      default: state_d = clcd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clcd_pkg::BK_IDLE;
      ov_q    <= 1'b0;
      idx_q   <= 4'd0;
      ndig_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
      ndig_q  <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    od_q  <= od_d;
    if (take_job) job_q <= job_i;
    if (state_q == clcd_pkg::BK_CONV) dig_q[ndig_q] <= qdig;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  `CLCD_ASSERT(a_no_take_busy, take_job |-> state_q == clcd_pkg::BK_IDLE, "job taken while busy")
  `CLCD_ASSERT(a_conv_bound, state_q == clcd_pkg::BK_CONV |-> ndig_q < 3'd5, "too many digits")
  `CLCD_ASSERT(a_emit_loads, emit |=> ov_q, "emitted item not registered")
  `CLCD_ASSERT(a_last_idle, emit && item.last |=> state_q == clcd_pkg::BK_IDLE, "run did not end")

endmodule

/* rtl/char_lcd_nibble_command_engine.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_engine
// Expands LCD commands into nibble strobe transfers for a 4-bit interface.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in      | input     | clcd_pkg::in_item_t  (cmd, value, column, row)
//  out     | output    | clcd_pkg::out_item_t (reg_select, nibble, strobe_res, wait_us, last)
//
// One result transfer a cycle while the output is taken; a number command
// first runs the divide-by-ten step once for each decimal digit.
// A command yields up to 15 results, and the back passes through idle between commands.
// A two-entry queue lets the front accept commands while the back is busy.
// Reset is asynchronous, active low, and clears all control state.
// ----------------------------------------------------------------------------
module char_lcd_nibble_command_engine #(
  parameter int unsigned Columns = clcd_pkg::DefColumns,
  parameter int unsigned Rows    = clcd_pkg::DefRows
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  clcd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clcd_pkg::out_item_t out_data_o
);

  logic           f_valid, f_ready, q_valid, q_ready;
  clcd_pkg::job_t f_job, q_job;

  clcd_front #(.Columns(Columns), .Rows(Rows)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  clcd_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  clcd_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
